// ----- rtl/ray_sphere_nearest_hit_top_assert.svh -----
// Assertion macros shared by the checker.
`ifndef RAY_SPHERE_NEAREST_HIT_TOP_ASSERT_SVH
`define RAY_SPHERE_NEAREST_HIT_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RSHN_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rshn assertion failed");

// Next-cycle implication, checked outside reset.
`define RSHN_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rshn assertion failed");

`endif

// ----- rtl/rshn_pkg.sv -----
`timescale 1ns / 1ps

package rshn_pkg;

    // Field widths of the words on the channels.
    localparam int COORD_W = 40;
    localparam int RAD_W   = 39;
    localparam int DIST_W  = 39;
    localparam int IDX_W   = 4;
    localparam int NEAR_W  = 17;

    localparam int RSHN_MAX_SPHERES = 16;

    localparam logic [NEAR_W-1:0] NEAR_RESET = NEAR_W'(7);
    localparam logic [DIST_W-1:0] FAR_RESET  = {DIST_W{1'b1}};

    // Configuration port.
    localparam int   ADDR_W   = 4;
    localparam int   APB_W    = 64;
    localparam logic REG_NEAR = 1'b0;
    localparam logic REG_FAR  = 1'b1;

    // Datapath widths.
    localparam int OC_W   = 41;
    localparam int A_W    = 80;
    localparam int B_W    = 83;
    localparam int C_W    = 84;
    localparam int D_W    = 163;
    localparam int SQ_W   = 162;
    localparam int S_W    = 81;
    localparam int SR_W   = 84;
    localparam int OPND_W = 88;
    localparam int SMALL_OPND_W = 48;
    localparam int PROD_W = 176;
    localparam int NUM_W  = 85;
    localparam int MAG_W  = 84;
    localparam int FRAC_W = 16;
    localparam int QT_W   = 41;
    localparam int REM_W  = 81;
    localparam int T_W    = 40;
    localparam int CNT_W  = 7;

    localparam int SMALL_STEPS = 6;
    localparam int LARGE_STEPS = 11;
    localparam int SQRT_STEPS  = 81;
    localparam int DIV_STEPS   = 41;

    localparam logic signed [T_W-1:0] T_MIN = {1'b1, {(T_W-1){1'b0}}};
    localparam logic signed [T_W-1:0] T_MAX = {1'b0, {(T_W-1){1'b1}}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MLOAD,
        ST_MRUN,
        ST_MACC,
        ST_CHECK,
        ST_SQRT,
        ST_DLOAD,
        ST_DIV,
        ST_DEND,
        ST_DTEST,
        ST_FIN
    } state_t;

    // Products in the order they are formed.
    typedef enum logic [3:0] {
        MOP_AX,
        MOP_AY,
        MOP_AZ,
        MOP_BX,
        MOP_BY,
        MOP_BZ,
        MOP_CX,
        MOP_CY,
        MOP_CZ,
        MOP_R,
        MOP_BB,
        MOP_AC
    } mop_t;

    typedef struct packed {
        logic capture;
        logic mul_load;
        logic mul_step;
        logic mul_acc;
        mop_t mop;
        logic sqrt_init;
        logic sqrt_step;
        logic div_load;
        logic div_step;
        logic div_end;
        logic root_far;
        logic finish;
        logic hit_ok;
    } cmd_t;

    typedef struct packed {
        logic a_zero;
        logic disc_neg;
        logic t_pos;
        logic last;
        logic out_free;
    } sts_t;

endpackage

// ----- rtl/rshn_ray_if.sv -----
`timescale 1ns / 1ps

interface rshn_ray_if
    import rshn_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [COORD_W-1:0] direction_x;
    logic signed [COORD_W-1:0] direction_y;
    logic signed [COORD_W-1:0] direction_z;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic        [RAD_W-1:0]   radius;
    logic                      last_sphere;

    modport source (
        output valid, origin_x, origin_y, origin_z, direction_x, direction_y,
               direction_z, center_x, center_y, center_z, radius, last_sphere,
        input  ready
    );

    modport sink (
        input  valid, origin_x, origin_y, origin_z, direction_x, direction_y,
               direction_z, center_x, center_y, center_z, radius, last_sphere,
        output ready
    );
endinterface

// ----- rtl/rshn_hit_if.sv -----
`timescale 1ns / 1ps

interface rshn_hit_if
    import rshn_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              hit;
    logic [DIST_W-1:0] nearest_distance;
    logic [IDX_W-1:0]  sphere_index;

    modport source (
        output valid, hit, nearest_distance, sphere_index,
        input  ready
    );

    modport sink (
        input  valid, hit, nearest_distance, sphere_index,
        output ready
    );
endinterface

// ----- rtl/rshn_ctrl.sv -----
`timescale 1ns / 1ps

module rshn_ctrl
    import rshn_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    mop_t              mop_reg, mop_next;
    logic              sel_reg, sel_next;
    logic              hit_ok_reg, hit_ok_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            mop_reg    <= MOP_AX;
            sel_reg    <= 1'b0;
            hit_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            mop_reg    <= mop_next;
            sel_reg    <= sel_next;
            hit_ok_reg <= hit_ok_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        mop_next     = mop_reg;
        sel_next     = sel_reg;
        hit_ok_next  = hit_ok_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.mop      = mop_reg;
        cmd.root_far = sel_reg;
        cmd.hit_ok   = hit_ok_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    mop_next    = MOP_AX;
                    sel_next    = 1'b0;
                    state_next  = ST_MLOAD;
                end
            end
            ST_MLOAD:
            begin
                cmd.mul_load = 1'b1;
                if (mop_reg == MOP_BB || mop_reg == MOP_AC)
                    cnt_next = CNT_W'(LARGE_STEPS - 1);
                else
                    cnt_next = CNT_W'(SMALL_STEPS - 1);
                state_next = ST_MRUN;
            end
            ST_MRUN:
            begin
                cmd.mul_step = 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_MACC;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            ST_MACC:
            begin
                cmd.mul_acc = 1'b1;
                if (mop_reg == MOP_AC)
                    state_next = ST_CHECK;
                else
                begin
                    mop_next   = mop_t'(4'(mop_reg + 4'd1));
                    state_next = ST_MLOAD;
                end
            end
            ST_CHECK:
            begin
                if (sts.a_zero || sts.disc_neg)
                begin
                    hit_ok_next = 1'b0;
                    state_next  = ST_FIN;
                end
                else
                begin
                    cmd.sqrt_init = 1'b1;
                    cnt_next      = CNT_W'(SQRT_STEPS - 1);
                    state_next    = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_DLOAD;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            ST_DLOAD:
            begin
                cmd.div_load = 1'b1;
                cnt_next     = CNT_W'(DIV_STEPS - 1);
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_DEND;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            ST_DEND:
            begin
                cmd.div_end = 1'b1;
                state_next  = ST_DTEST;
            end
            ST_DTEST:
            begin
                if (!sel_reg && !sts.t_pos)
                begin
                    sel_next   = 1'b1;
                    state_next = ST_DLOAD;
                end
                else
                begin
                    hit_ok_next = 1'b1;
                    state_next  = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!sts.last || sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/rshn_dp.sv -----
`timescale 1ns / 1ps

module rshn_dp
    import rshn_pkg::*;
#(
    parameter int MAX_SPHERES = RSHN_MAX_SPHERES
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cmd_t                      cmd,
    output sts_t                      sts,
    input  logic signed [COORD_W-1:0] origin_x,
    input  logic signed [COORD_W-1:0] origin_y,
    input  logic signed [COORD_W-1:0] origin_z,
    input  logic signed [COORD_W-1:0] direction_x,
    input  logic signed [COORD_W-1:0] direction_y,
    input  logic signed [COORD_W-1:0] direction_z,
    input  logic signed [COORD_W-1:0] center_x,
    input  logic signed [COORD_W-1:0] center_y,
    input  logic signed [COORD_W-1:0] center_z,
    input  logic        [RAD_W-1:0]   radius,
    input  logic                      last_sphere,
    input  logic        [NEAR_W-1:0]  near_limit,
    input  logic        [DIST_W-1:0]  far_limit,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      out_hit,
    output logic        [DIST_W-1:0]  out_dist,
    output logic        [IDX_W-1:0]   out_idx
);

    localparam int CIDX_W = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;

    function automatic logic [OC_W-1:0] mag41(input logic signed [OC_W-1:0] v);
        mag41 = v[OC_W-1] ? OC_W'(-v) : OC_W'(v);
    endfunction

    // Captured operands.
    logic signed [OC_W-1:0]  d_reg [3];
    logic signed [OC_W-1:0]  oc_reg [3];
    logic        [RAD_W-1:0] r_reg;
    logic                    last_reg;

    // Quadratic coefficients and discriminant.
    logic        [A_W-1:0] a_reg;
    logic signed [B_W-1:0] b_reg;
    logic signed [C_W-1:0] c_reg;
    logic signed [D_W-1:0] disc_reg;

    // Shift-add multiplier, one byte of the multiplier per cycle.
    logic [OPND_W-1:0] mx_reg;
    logic [OPND_W-1:0] my_reg;
    logic [PROD_W-1:0] acc_reg;

    // Square root and divider.
    logic [SQ_W-1:0]  sq_src_reg;
    logic [SR_W-1:0]  sq_rem_reg;
    logic [S_W-1:0]   sq_root_reg;
    logic [REM_W-1:0] dv_rem_reg;
    logic [QT_W-1:0]  dv_low_reg;
    logic [QT_W-1:0]  dv_q_reg;
    logic             dv_over_reg;
    logic             dv_neg_reg;
    logic signed [T_W-1:0] t_reg;

    // Run state.
    logic [DIST_W-1:0] best_reg;
    logic [CIDX_W-1:0] best_idx_reg;
    logic              found_reg;
    logic [CIDX_W-1:0] count_reg;

    logic              out_valid_reg;
    logic              out_hit_reg;
    logic [DIST_W-1:0] out_dist_reg;
    logic [IDX_W-1:0]  out_idx_reg;

    logic signed [OC_W-1:0] src_x, src_y;
    logic [OC_W-1:0]        mag_x, mag_y;
    logic                   prod_neg;
    logic                   large_op;
    logic [B_W-1:0]         b_mag;
    logic [C_W-1:0]         c_mag;

    always_comb
    begin
        src_x = d_reg[0];
        src_y = d_reg[0];
        unique case (cmd.mop)
            MOP_AX: begin src_x = d_reg[0];  src_y = d_reg[0]; end
            MOP_AY: begin src_x = d_reg[1];  src_y = d_reg[1]; end
            MOP_AZ: begin src_x = d_reg[2];  src_y = d_reg[2]; end
            MOP_BX: begin src_x = oc_reg[0]; src_y = d_reg[0]; end
            MOP_BY: begin src_x = oc_reg[1]; src_y = d_reg[1]; end
            MOP_BZ: begin src_x = oc_reg[2]; src_y = d_reg[2]; end
            MOP_CX: begin src_x = oc_reg[0]; src_y = oc_reg[0]; end
            MOP_CY: begin src_x = oc_reg[1]; src_y = oc_reg[1]; end
            MOP_CZ: begin src_x = oc_reg[2]; src_y = oc_reg[2]; end
            MOP_R:
            begin
                src_x = $signed(OC_W'(r_reg));
                src_y = $signed(OC_W'(r_reg));
            end
            default: begin src_x = d_reg[0]; src_y = d_reg[0]; end
        endcase
    end

    assign mag_x    = mag41(src_x);
    assign mag_y    = mag41(src_y);
    assign prod_neg = src_x[OC_W-1] ^ src_y[OC_W-1];
    assign large_op = (cmd.mop == MOP_BB) || (cmd.mop == MOP_AC);
    assign b_mag    = b_reg[B_W-1] ? B_W'(-b_reg) : B_W'(b_reg);
    assign c_mag    = c_reg[C_W-1] ? C_W'(-c_reg) : C_W'(c_reg);

    logic signed [B_W-1:0] pb;
    logic signed [C_W-1:0] pc;
    logic signed [D_W-1:0] pd;
    logic [PROD_W-1:0]     part;

    assign pb   = $signed(acc_reg[B_W-1:0]);
    assign pc   = $signed(acc_reg[C_W-1:0]);
    assign pd   = $signed(acc_reg[D_W-1:0]);
    assign part = PROD_W'(mx_reg * my_reg[OPND_W-1 -: 8]);

    // Root numerator -b -/+ s and its magnitude scaled by 2^16.
    logic signed [NUM_W-1:0]  num;
    logic                     num_neg;
    logic [MAG_W-1:0]         num_mag;
    logic [MAG_W+FRAC_W-1:0]  num_scaled;
    logic [MAG_W+FRAC_W-QT_W-1:0] num_high;

    always_comb
    begin
        if (cmd.root_far)
            num = -NUM_W'(b_reg) + $signed(NUM_W'(sq_root_reg));
        else
            num = -NUM_W'(b_reg) - $signed(NUM_W'(sq_root_reg));
        num_neg    = num[NUM_W-1];
        num_mag    = num_neg ? MAG_W'(-num) : MAG_W'(num);
        num_scaled = {num_mag, {FRAC_W{1'b0}}};
        num_high   = num_scaled[MAG_W+FRAC_W-1:QT_W];
    end

    logic [SR_W-1:0]  sq_rem2;
    logic [SR_W-1:0]  sq_trial;
    logic             sq_ge;
    logic [REM_W-1:0] dv_rem2;
    logic             dv_ge;

    assign sq_rem2  = {sq_rem_reg[SR_W-3:0], sq_src_reg[SQ_W-1 -: 2]};
    assign sq_trial = SR_W'({sq_root_reg, 2'b01});
    assign sq_ge    = sq_rem2 >= sq_trial;
    assign dv_rem2  = {dv_rem_reg[REM_W-2:0], dv_low_reg[QT_W-1]};
    assign dv_ge    = dv_rem2 >= REM_W'(a_reg);

    // Closing of a sphere: candidate test and run bookkeeping.
    logic              cand;
    logic [DIST_W-1:0] new_best;
    logic [CIDX_W-1:0] new_idx;
    logic              new_found;

    always_comb
    begin
        cand = cmd.hit_ok && !t_reg[T_W-1]
               && (t_reg[DIST_W-1:0] > DIST_W'(near_limit))
               && (t_reg[DIST_W-1:0] < best_reg);
        new_best  = cand ? t_reg[DIST_W-1:0] : best_reg;
        new_idx   = cand ? count_reg : best_idx_reg;
        new_found = cand || found_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            d_reg[0]  <= OC_W'(direction_x);
            d_reg[1]  <= OC_W'(direction_y);
            d_reg[2]  <= OC_W'(direction_z);
            oc_reg[0] <= OC_W'(origin_x) - OC_W'(center_x);
            oc_reg[1] <= OC_W'(origin_y) - OC_W'(center_y);
            oc_reg[2] <= OC_W'(origin_z) - OC_W'(center_z);
            r_reg     <= radius;
            last_reg  <= last_sphere;
            a_reg     <= '0;
            b_reg     <= '0;
            c_reg     <= '0;
        end

        if (cmd.mul_load)
        begin
            acc_reg <= '0;
            if (large_op)
            begin
                mx_reg <= (cmd.mop == MOP_BB) ? OPND_W'(b_mag) : OPND_W'(a_reg);
                my_reg <= (cmd.mop == MOP_BB) ? OPND_W'(b_mag) : OPND_W'(c_mag);
            end
            else
            begin
                mx_reg <= OPND_W'(mag_x);
                my_reg <= {SMALL_OPND_W'(mag_y), {(OPND_W-SMALL_OPND_W){1'b0}}};
            end
        end
        else if (cmd.mul_step)
        begin
            acc_reg <= {acc_reg[PROD_W-9:0], 8'h00} + part;
            my_reg  <= {my_reg[OPND_W-9:0], 8'h00};
        end

        if (cmd.mul_acc)
        begin
            unique case (cmd.mop)
                MOP_AX, MOP_AY, MOP_AZ:
                    a_reg <= a_reg + acc_reg[A_W-1:0];
                MOP_BX, MOP_BY, MOP_BZ:
                    b_reg <= prod_neg ? b_reg - pb : b_reg + pb;
                MOP_CX, MOP_CY, MOP_CZ:
                    c_reg <= c_reg + pc;
                MOP_R:
                    c_reg <= c_reg - pc;
                MOP_BB:
                    disc_reg <= pd;
                MOP_AC:
                    disc_reg <= c_reg[C_W-1] ? disc_reg + pd : disc_reg - pd;
                default:
                    a_reg <= a_reg;
            endcase
        end

        if (cmd.sqrt_init)
        begin
            sq_src_reg  <= disc_reg[SQ_W-1:0];
            sq_rem_reg  <= '0;
            sq_root_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            sq_src_reg  <= {sq_src_reg[SQ_W-3:0], 2'b00};
            sq_rem_reg  <= sq_ge ? sq_rem2 - sq_trial : sq_rem2;
            sq_root_reg <= {sq_root_reg[S_W-2:0], sq_ge};
        end

        if (cmd.div_load)
        begin
            dv_over_reg <= A_W'(num_high) >= a_reg;
            dv_neg_reg  <= num_neg;
            dv_rem_reg  <= REM_W'(num_high);
            dv_low_reg  <= num_scaled[QT_W-1:0];
            dv_q_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            dv_rem_reg <= dv_ge ? dv_rem2 - REM_W'(a_reg) : dv_rem2;
            dv_low_reg <= {dv_low_reg[QT_W-2:0], 1'b0};
            dv_q_reg   <= {dv_q_reg[QT_W-2:0], dv_ge};
        end

        if (cmd.div_end)
        begin
            if (dv_neg_reg)
            begin
                if (dv_over_reg || dv_q_reg > QT_W'(T_MAX) + QT_W'(1))
                    t_reg <= T_MIN;
                else
                    t_reg <= -$signed(T_W'(dv_q_reg));
            end
            else
            begin
                if (dv_over_reg || dv_q_reg[QT_W-1:T_W-1] != '0)
                    t_reg <= T_MAX;
                else
                    t_reg <= $signed(T_W'(dv_q_reg));
            end
        end

        if (cmd.finish && last_reg)
        begin
            out_hit_reg  <= new_found;
            out_dist_reg <= new_found ? new_best : '0;
            out_idx_reg  <= new_found ? IDX_W'(new_idx) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg      <= FAR_RESET;
            best_idx_reg  <= '0;
            found_reg     <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                if (last_reg)
                begin
                    best_reg     <= far_limit;
                    best_idx_reg <= '0;
                    found_reg    <= 1'b0;
                    count_reg    <= '0;
                end
                else
                begin
                    best_reg     <= new_best;
                    best_idx_reg <= new_idx;
                    found_reg    <= new_found;
                    if (count_reg == CIDX_W'(MAX_SPHERES - 1))
                        count_reg <= '0;
                    else
                        count_reg <= count_reg + 1'b1;
                end
            end

            if (cmd.finish && last_reg)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign sts.a_zero   = (a_reg == '0);
    assign sts.disc_neg = disc_reg[D_W-1];
    assign sts.t_pos    = !t_reg[T_W-1] && (t_reg != '0);
    assign sts.last     = last_reg;
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_hit   = out_hit_reg;
    assign out_dist  = out_dist_reg;
    assign out_idx   = out_idx_reg;

endmodule

// ----- rtl/ray_sphere_nearest_hit_top.sv -----
`timescale 1ns / 1ps

// Ray against sphere, nearest hit over a run of spheres.
// ray_in (sink) carries one word per sphere: ray origin and direction, sphere
// centre, all Q24.16, radius unsigned Q23.16, last_sphere to close the run.
// hit_out (source) carries one word per run: hit flag, nearest distance and
// the position of that sphere in the run. A valid/ready pair moves each word.
// The APB port holds near_limit at byte address 0 and far_limit at 8; the
// data bus is 64 bits wide, pready is tied high and reads return the value.
// Each word is worked on alone. A miss with zero direction or a negative
// discriminant skips the square root and the divider; a hit also tries the
// far root when the near root does not lie ahead of the origin. The work is
// done by the byte-serial multiplier (twelve products), the bit-pair square
// root (81 steps) and the bit-serial divider (41 steps per root).
// At reset the limits return to 7 and 2^39-1 and the run is cleared. The
// result of a run sits in an output register, so the next word of the
// following run is taken while that result waits; only a second run end
// stalls, in its final state, until the receiver has taken the first word.

module ray_sphere_nearest_hit_top
    import rshn_pkg::*;
#(
    parameter int MAX_SPHERES = RSHN_MAX_SPHERES
) (
    input  logic              clk,
    input  logic              rst_n,
    rshn_ray_if.sink          ray_in,
    rshn_hit_if.source        hit_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready
);

    logic [NEAR_W-1:0] near_reg;
    logic [DIST_W-1:0] far_reg;
    logic              cfg_write;
    logic              reg_sel;

    cmd_t cmd;
    sts_t sts;

    // Register index is the address divided by eight.
    assign reg_sel   = paddr[3];
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_reg <= NEAR_RESET;
            far_reg  <= FAR_RESET;
        end
        else if (cfg_write)
        begin
            if (reg_sel == REG_NEAR)
                near_reg <= pwdata[NEAR_W-1:0];
            else
                far_reg <= pwdata[DIST_W-1:0];
        end
    end

    assign prdata = (reg_sel == REG_FAR) ? APB_W'(far_reg) : APB_W'(near_reg);

    // The controller sequences the products, the root and the divisions.
    rshn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (ray_in.valid),
        .in_ready (ray_in.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the operands, the arithmetic units, the run state
    // and the output register.
    rshn_dp #(
        .MAX_SPHERES (MAX_SPHERES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .origin_x    (ray_in.origin_x),
        .origin_y    (ray_in.origin_y),
        .origin_z    (ray_in.origin_z),
        .direction_x (ray_in.direction_x),
        .direction_y (ray_in.direction_y),
        .direction_z (ray_in.direction_z),
        .center_x    (ray_in.center_x),
        .center_y    (ray_in.center_y),
        .center_z    (ray_in.center_z),
        .radius      (ray_in.radius),
        .last_sphere (ray_in.last_sphere),
        .near_limit  (near_reg),
        .far_limit   (far_reg),
        .out_valid   (hit_out.valid),
        .out_ready   (hit_out.ready),
        .out_hit     (hit_out.hit),
        .out_dist    (hit_out.nearest_distance),
        .out_idx     (hit_out.sphere_index)
    );

endmodule

// ----- rtl/rshn_checker.sv -----
`timescale 1ns / 1ps

`include "ray_sphere_nearest_hit_top_assert.svh"

module rshn_checker
    import rshn_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic              out_hit,
    input logic [DIST_W-1:0] out_dist,
    input logic [IDX_W-1:0]  out_idx,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [ADDR_W-1:0] paddr,
    input logic [APB_W-1:0]  pwdata,
    input logic [APB_W-1:0]  prdata
);

    // A word under way blocks the next one.
    `RSHN_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

    // A stalled result stays offered and unchanged.
    `RSHN_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `RSHN_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
        $stable(out_hit) && $stable(out_dist) && $stable(out_idx))

    // A near limit that was written reads back on the next cycle.
    `RSHN_ASSERT_NEXT(a_near_readback, psel && penable && pwrite && !paddr[3],
        paddr[3] || prdata == APB_W'($past(pwdata[NEAR_W-1:0])))

endmodule

bind ray_sphere_nearest_hit_top rshn_checker u_rshn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ray_in.valid),
    .in_ready  (ray_in.ready),
    .out_valid (hit_out.valid),
    .out_ready (hit_out.ready),
    .out_hit   (hit_out.hit),
    .out_dist  (hit_out.nearest_distance),
    .out_idx   (hit_out.sphere_index),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
);
